FILE: src/rlf_pkg.sv
// ----------------------------------------------------------------------------
// rlf_pkg
// Shared widths, types and constants of the line fitting core.
// ----------------------------------------------------------------------------
package rlf_pkg;

    localparam int unsigned IDX_W       = 9;
    localparam int unsigned COORD_W     = 16;
    localparam int unsigned DELTA_W     = COORD_W + 1;
    localparam int unsigned PROD_W      = 2 * DELTA_W;
    localparam int unsigned CNT_W       = IDX_W + 1;
    localparam int unsigned SUM_W       = PROD_W + IDX_W + 1;
    localparam int unsigned RAD_W       = PROD_W + 16;
    localparam int unsigned ROOT_W      = RAD_W / 2;
    localparam int unsigned NUM_W       = SUM_W + 24;
    localparam int unsigned DEN_W       = CNT_W + ROOT_W;
    localparam int unsigned SLOPE_W     = 32;
    localparam int unsigned ICPT_W      = 48;
    localparam int unsigned ERR_W       = 48;
    localparam int unsigned IN_TDATA_W  = 64;
    localparam int unsigned OUT_TDATA_W = 128;

    localparam logic [ERR_W-1:0] ERR_RESET = 48'd6553600000000;

    localparam logic CFG_FIRST = 1'b0;
    localparam logic CFG_LAST  = 1'b1;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_TRIAL = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_point;

endpackage

FILE: src/ransac_line_fit_core.sv
// ----------------------------------------------------------------------------
// ransac_line_fit_core
// Line fitting over a store of scan points: loads points, runs trials on
// host-chosen sample pairs and reports the best line on the last trial.
//
// Channel   Dir  Beat contents
// s_axis    in   tuser=action, tlast=last_trial, tdata=index,x,y,sample_a,b
// m_axis    out  tuser=found, tdata=slope,intercept,mean_error
// cfg       in   write of first_index or last_index
//
// A trial walks the window, one point store read a cycle, then takes the
// square root and up to three divisions; a skipped trial goes straight to
// the finishing step. A load leaves the core idle. Reset is synchronous,
// clears the best result and returns the window registers to 0 and 359.
// A last trial whose result finds the output still full waits for it.
// ----------------------------------------------------------------------------
module ransac_line_fit_core #(
    parameter int unsigned POINTS = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // point_index, point_x, point_y, sample_a, sample_b (lowest bit up)
    input  logic [rlf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // action
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // slope, intercept, mean_error (lowest bit up)
    output logic [rlf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // found
    output logic                                m_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [rlf_pkg::IDX_W-1:0]           i_cfg_data
);

    localparam int unsigned AW  = $clog2(POINTS);
    localparam int unsigned IW  = rlf_pkg::IDX_W;
    localparam int unsigned CW  = rlf_pkg::COORD_W;
    localparam int unsigned DLW = rlf_pkg::DELTA_W;
    localparam int unsigned PW  = rlf_pkg::PROD_W;
    localparam int unsigned SW  = rlf_pkg::SUM_W;
    localparam int unsigned NW  = rlf_pkg::NUM_W;
    localparam int unsigned DW  = rlf_pkg::DEN_W;
    localparam int unsigned RTW = rlf_pkg::ROOT_W;
    localparam int unsigned EW  = rlf_pkg::ERR_W;
    localparam int unsigned KW  = rlf_pkg::CNT_W;
    localparam logic [IW-1:0] LAST_PT = IW'(POINTS - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RA   = 4'd1;
    localparam logic [3:0] S_RB   = 4'd2;
    localparam logic [3:0] S_PS   = 4'd3;
    localparam logic [3:0] S_PI   = 4'd4;
    localparam logic [3:0] S_PW   = 4'd5;
    localparam logic [3:0] S_WALK = 4'd6;
    localparam logic [3:0] S_DRN  = 4'd7;
    localparam logic [3:0] S_SQRT = 4'd8;
    localparam logic [3:0] S_MUL  = 4'd9;
    localparam logic [3:0] S_DIVE = 4'd10;
    localparam logic [3:0] S_DIVS = 4'd11;
    localparam logic [3:0] S_DIVI = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;

    rlf_pkg::t_point mem [POINTS];
    rlf_pkg::t_point r_rdata;

    logic [3:0]    r_state;
    logic [3:0]    n_state;
    logic [IW-1:0] r_first;
    logic [IW-1:0] r_last_idx;
    logic [IW-1:0] r_b;
    logic [IW-1:0] r_j;
    logic [IW-1:0] r_end;
    logic          r_lt;

    logic signed [CW-1:0]  r_xa;
    logic signed [CW-1:0]  r_ya;
    logic signed [DLW-1:0] r_dx;
    logic signed [DLW-1:0] r_dy;
    logic signed [DLW-1:0] r_ex;
    logic signed [DLW-1:0] r_ey;
    logic signed [PW-1:0]  r_p1;
    logic signed [PW-1:0]  r_p2;
    logic [PW-1:0]         r_s;
    logic signed [PW:0]    r_inum;
    logic [SW-1:0]         r_sum;
    logic [KW-1:0]         r_cnt;
    logic [RTW-1:0]        r_len;
    logic                  r_rd_v;
    logic                  r_e_v;
    logic                  r_e_nz;
    logic                  r_p_v;
    logic                  r_p_nz;

    logic          r_div_go;
    logic [NW-1:0] r_div_num;
    logic [DW-1:0] r_div_den;
    logic          w_div_busy;
    logic          w_div_done;
    logic [NW-1:0] w_quot;
    logic          w_sq_start;
    logic          w_sq_done;
    logic [RTW-1:0] w_root;

    logic signed [31:0] r_best_slope;
    logic signed [47:0] r_best_icpt;
    logic [EW-1:0]      r_best_err;
    logic               r_best_found;

    logic                               r_out_v;
    logic [rlf_pkg::OUT_TDATA_W-1:0]    r_out_data;
    logic                               r_out_found;

    logic [IW-1:0] w_pidx;
    logic [IW-1:0] w_sa;
    logic [IW-1:0] w_sb;
    logic [IW-1:0] w_raddr_idx;
    logic [31:0]   w_raddr_wide;
    logic [31:0]   w_waddr_wide;
    logic          w_acc;
    logic          w_skip;
    logic          w_drained;
    logic          w_emit;

    logic signed [DLW-1:0] w_oa1;
    logic signed [DLW-1:0] w_ob1;
    logic signed [DLW-1:0] w_oa2;
    logic signed [DLW-1:0] w_ob2;
    logic signed [PW:0]    w_diff;
    logic [PW:0]           w_mag;
    logic [DLW-1:0]        w_adx;
    logic [DLW-1:0]        w_ady;
    logic [PW:0]           w_ainum;
    logic                  w_neg_s;
    logic                  w_neg_i;
    logic [EW-1:0]         w_err;
    logic [31:0]           w_qs;
    logic [47:0]           w_qi;

    assign w_pidx = s_axis_tdata[8:0];
    assign w_sa   = s_axis_tdata[49:41];
    assign w_sb   = s_axis_tdata[58:50];
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    assign w_skip = (r_first > r_last_idx) || (w_sa < r_first) || (w_sa > r_last_idx)
                  || (w_sb < r_first) || (w_sb > r_last_idx)
                  || (32'(w_sa) >= POINTS) || (32'(w_sb) >= POINTS);

    always_comb begin
        case (r_state)
            S_RA:    w_raddr_idx = r_b;
            S_WALK:  w_raddr_idx = r_j;
            default: w_raddr_idx = w_sa;
        endcase
    end
    assign w_raddr_wide = 32'(w_raddr_idx);
    assign w_waddr_wide = 32'(w_pidx);

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[w_raddr_wide[AW-1:0]];
        if (w_acc && s_axis_tuser == rlf_pkg::ACT_LOAD && 32'(w_pidx) < POINTS) begin
            mem[w_waddr_wide[AW-1:0]] <= {s_axis_tdata[40:25], s_axis_tdata[24:9]};
        end
    end

    always_comb begin
        w_oa1 = r_dy;
        w_ob1 = r_ex;
        w_oa2 = r_dx;
        w_ob2 = r_ey;
        case (r_state)
            S_PS: begin
                w_ob1 = r_dy;
                w_ob2 = r_dx;
            end
            S_PI: begin
                w_oa1 = r_dx;
                w_ob1 = {r_ya[CW-1], r_ya};
                w_oa2 = r_dy;
                w_ob2 = {r_xa[CW-1], r_xa};
            end
            default: ;
        endcase
    end

    assign w_diff  = {r_p1[PW-1], r_p1} - {r_p2[PW-1], r_p2};
    assign w_mag   = w_diff[PW] ? -w_diff : w_diff;
    assign w_adx   = r_dx[DLW-1] ? -r_dx : r_dx;
    assign w_ady   = r_dy[DLW-1] ? -r_dy : r_dy;
    assign w_ainum = r_inum[PW] ? -r_inum : r_inum;
    assign w_neg_s = r_dy[DLW-1] ^ r_dx[DLW-1];
    assign w_neg_i = r_inum[PW] ^ r_dx[DLW-1];
    assign w_err   = (w_quot > NW'({EW{1'b1}})) ? {EW{1'b1}} : w_quot[EW-1:0];

    always_comb begin
        if (w_neg_s) begin
            w_qs = (w_quot > NW'(33'h0_8000_0000)) ? 32'h8000_0000 : w_quot[31:0];
            w_qs = -w_qs;
        end else begin
            w_qs = (w_quot > NW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : w_quot[31:0];
        end
        if (w_neg_i) begin
            w_qi = (w_quot > NW'(49'h0_8000_0000_0000)) ? 48'h8000_0000_0000 : w_quot[47:0];
            w_qi = -w_qi;
        end else begin
            w_qi = (w_quot > NW'(48'h7FFF_FFFF_FFFF)) ? 48'h7FFF_FFFF_FFFF : w_quot[47:0];
        end
    end

    assign w_drained  = !r_rd_v && !r_e_v && !r_p_v;
    assign w_sq_start = (r_state == S_DRN) && w_drained && (r_cnt != '0);
    assign w_emit     = (r_state == S_FIN) && r_lt && (!r_out_v || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc && s_axis_tuser == rlf_pkg::ACT_TRIAL) begin
                    n_state = w_skip ? S_FIN : S_RA;
                end
            end
            S_RA:   n_state = S_RB;
            S_RB:   n_state = S_PS;
            S_PS:   n_state = (r_dx == '0) ? S_FIN : S_PI;
            S_PI:   n_state = S_PW;
            S_PW:   n_state = S_WALK;
            S_WALK: n_state = (r_j == r_end) ? S_DRN : S_WALK;
            S_DRN: begin
                if (w_drained) begin
                    n_state = (r_cnt == '0) ? S_FIN : S_SQRT;
                end
            end
            S_SQRT: n_state = w_sq_done ? S_MUL : S_SQRT;
            S_MUL:  n_state = S_DIVE;
            S_DIVE: begin
                if (w_div_done) begin
                    n_state = (w_err < r_best_err) ? S_DIVS : S_FIN;
                end
            end
            S_DIVS: n_state = w_div_done ? S_DIVI : S_DIVS;
            S_DIVI: n_state = w_div_done ? S_FIN : S_DIVI;
            S_FIN: begin
                if (!r_lt || w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_first      <= '0;
            r_last_idx   <= IW'(359);
            r_rd_v       <= 1'b0;
            r_e_v        <= 1'b0;
            r_p_v        <= 1'b0;
            r_div_go     <= 1'b0;
            r_out_v      <= 1'b0;
            r_best_slope <= '0;
            r_best_icpt  <= '0;
            r_best_err   <= rlf_pkg::ERR_RESET;
            r_best_found <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_v   <= (r_state == S_WALK);
            r_e_v    <= r_rd_v;
            r_p_v    <= r_e_v;
            r_div_go <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == rlf_pkg::CFG_FIRST) begin
                    r_first <= i_cfg_data;
                end else begin
                    r_last_idx <= i_cfg_data;
                end
            end
            if (r_state == S_MUL) begin
                r_div_go <= 1'b1;
            end
            if (r_state == S_DIVE && w_div_done && w_err < r_best_err) begin
                r_best_err <= w_err;
                r_div_go   <= 1'b1;
            end
            if (r_state == S_DIVS && w_div_done) begin
                r_best_slope <= w_qs;
                r_div_go     <= 1'b1;
            end
            if (r_state == S_DIVI && w_div_done) begin
                r_best_icpt  <= w_qi;
                r_best_found <= 1'b1;
            end
            if (w_emit) begin
                r_out_v      <= 1'b1;
                r_best_slope <= '0;
                r_best_icpt  <= '0;
                r_best_err   <= rlf_pkg::ERR_RESET;
                r_best_found <= 1'b0;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1 <= w_oa1 * w_ob1;
        r_p2 <= w_oa2 * w_ob2;
        if (w_acc) begin
            r_b   <= w_sb;
            r_lt  <= s_axis_tlast;
            r_end <= (32'(r_last_idx) < POINTS) ? r_last_idx : LAST_PT;
        end
        if (r_state == S_RA) begin
            r_xa <= r_rdata.x;
            r_ya <= r_rdata.y;
        end
        if (r_state == S_RB) begin
            r_dx <= {r_rdata.x[CW-1], r_rdata.x} - {r_xa[CW-1], r_xa};
            r_dy <= {r_rdata.y[CW-1], r_rdata.y} - {r_ya[CW-1], r_ya};
        end
        if (r_state == S_PI) begin
            r_s <= PW'(r_p1 + r_p2);
        end
        if (r_state == S_PW) begin
            r_inum <= w_diff;
            r_j    <= r_first;
            r_sum  <= '0;
            r_cnt  <= '0;
        end
        if (r_state == S_WALK) begin
            r_j <= r_j + 1'b1;
        end
        r_ex   <= {r_rdata.x[CW-1], r_rdata.x} - {r_xa[CW-1], r_xa};
        r_ey   <= {r_rdata.y[CW-1], r_rdata.y} - {r_ya[CW-1], r_ya};
        r_e_nz <= (r_rdata.x != '0) || (r_rdata.y != '0);
        r_p_nz <= r_e_nz;
        if (r_p_v && r_p_nz) begin
            r_sum <= r_sum + SW'(w_mag);
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_state == S_SQRT && w_sq_done) begin
            r_len <= (w_root == '0) ? RTW'(1) : w_root;
        end
        if (r_state == S_MUL) begin
            r_div_num <= {r_sum, 24'd0};
            r_div_den <= DW'(r_cnt) * DW'(r_len);
        end
        if (r_state == S_DIVE) begin
            r_div_num <= NW'({w_ady, 16'd0});
            r_div_den <= DW'(w_adx);
        end
        if (r_state == S_DIVS) begin
            r_div_num <= NW'({w_ainum, 16'd0});
        end
        if (w_emit) begin
            r_out_data  <= {r_best_err, r_best_icpt, r_best_slope};
            r_out_found <= r_best_found;
        end
    end

    rlf_isqrt #(
        .W(rlf_pkg::RAD_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_rad   ({r_s, 16'd0}),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    rlf_divu #(
        .NW(NW),
        .DW(DW)
    ) u_divu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_found;

    a_emit_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == S_FIN)
        else $error("result raised outside the finishing step");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_go |-> !w_div_busy)
        else $error("divider started while busy");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> r_j <= r_end)
        else $error("walk index beyond window end");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata[31:0] == '0)
        else $error("slope nonzero without a found line");

endmodule

FILE: src/rlf_divu.sv
// ----------------------------------------------------------------------------
// rlf_divu
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rlf_divu #(
    parameter int unsigned NW = rlf_pkg::NUM_W,
    parameter int unsigned DW = rlf_pkg::DEN_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);

    localparam int unsigned CW = $clog2(NW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   w_sh;

    assign w_sh = {r_rem[DW-1:0], r_q[NW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                r_rem <= w_sh - {1'b0, r_den};
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: src/rlf_isqrt.sv
// ----------------------------------------------------------------------------
// rlf_isqrt
// Integer square root, digit by digit, one root bit per cycle.
// ----------------------------------------------------------------------------
module rlf_isqrt #(
    parameter int unsigned W = rlf_pkg::RAD_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_rad,
    output logic           o_done,
    output logic [W/2-1:0] o_root
);

    localparam int unsigned RTW = W / 2;
    localparam int unsigned RW  = RTW + 4;
    localparam int unsigned CW  = $clog2(RTW + 1);

    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [W-1:0]   r_rad;
    logic [RW-1:0]  r_rem;
    logic [RTW-1:0] r_root;
    logic [RW-1:0]  w_sh;
    logic [RW-1:0]  w_trial;

    assign w_sh    = {r_rem[RW-3:0], r_rad[W-1:W-2]};
    assign w_trial = RW'({r_root, 2'b01});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(RTW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[W-3:0], 2'b00};
            if (w_sh >= w_trial) begin
                r_rem  <= w_sh - w_trial;
                r_root <= {r_root[RTW-2:0], 1'b1};
            end else begin
                r_rem  <= w_sh;
                r_root <= {r_root[RTW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: tb/tb_ransac_line_fit_core.sv
// ----------------------------------------------------------------------------
// tb_ransac_line_fit_core
// Self-checking bench for the line fitting core. The point store is filled,
// then directed and random trials run over several fitting windows; a
// scoreboard predicts each reported best line and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ransac_line_fit_core;

    localparam int unsigned NPTS = 512;
    localparam int unsigned IXW  = rlf_pkg::IDX_W;
    localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic              act;
        logic [IXW-1:0]    idx;
        logic [15:0]       px;
        logic [15:0]       py;
        logic [IXW-1:0]    sa;
        logic [IXW-1:0]    sb;
        logic              last;
    } t_beat;

    typedef struct packed {
        logic [31:0] slope;
        logic [47:0] icpt;
        logic [47:0] err;
        logic        found;
    } t_fit;

    class line_fit_scoreboard;
        logic signed [15:0] sx [NPTS];
        logic signed [15:0] sy [NPTS];
        longint             win_lo, win_hi;
        t_fit               best;
        t_fit               fits_due [$];
        int                 errors;

        function new();
            win_lo = 0;
            win_hi = 359;
            clear_best();
            errors = 0;
        endfunction

        function void clear_best();
            best.slope = '0;
            best.icpt  = '0;
            best.err   = rlf_pkg::ERR_RESET;
            best.found = 1'b0;
        endfunction

        function void set_window(logic index, logic [IXW-1:0] value);
            if (index == rlf_pkg::CFG_FIRST) win_lo = longint'(value);
            else win_hi = longint'(value);
        endfunction

        function longint unsigned root(longint unsigned n);
            longint unsigned r, bitv;
            r = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (n >= r + bitv) begin
                    n = n - (r + bitv);
                    r = (r >> 1) + bitv;
                end else begin
                    r = r >> 1;
                end
                bitv = bitv >> 2;
            end
            return r;
        endfunction

        function logic [47:0] fix_div(longint num, longint den, int bits);
            bit              neg;
            longint unsigned q, lim, an, ad;
            neg = (num < 0) != (den < 0);
            an = (num < 0) ? -num : num;
            ad = (den < 0) ? -den : den;
            q = (an << 16) / ad;
            lim = 64'd1 << (bits - 1);
            if (neg) begin
                if (q > lim) q = lim;
                q = -q;
            end else if (q > lim - 1) begin
                q = lim - 1;
            end
            return (bits == 32) ? {16'd0, q[31:0]} : q[47:0];
        endfunction

        function void run_trial(int a, int b);
            longint          xa, ya, dx, dy, px, py, n;
            longint unsigned sum, cnt, len;
            logic [127:0]    q;
            logic [47:0]     e;
            if (win_lo > win_hi || a < win_lo || a > win_hi || b < win_lo || b > win_hi)
                return;
            xa = sx[a];
            ya = sy[a];
            dx = longint'(sx[b]) - xa;
            dy = longint'(sy[b]) - ya;
            if (dx == 0) return;
            sum = 0;
            cnt = 0;
            for (longint j = win_lo; j <= win_hi; j++) begin
                px = sx[j];
                py = sy[j];
                if (px != 0 || py != 0) begin
                    n = dy * (px - xa) - dx * (py - ya);
                    sum += (n < 0) ? -n : n;
                    cnt++;
                end
            end
            if (cnt == 0) return;
            len = root((dx * dx + dy * dy) << 16);
            if (len == 0) len = 1;
            q = ({64'd0, sum} << 24) / (128'(cnt) * 128'(len));
            e = (q > 128'(MASK48)) ? MASK48 : q[47:0];
            if (e < best.err) begin
                best.err   = e;
                best.slope = 32'(fix_div(dy, dx, 32));
                best.icpt  = fix_div(ya * dx - dy * xa, dx, 48);
                best.found = 1'b1;
            end
        endfunction

        function void note_beat(t_beat bt);
            if (bt.act == rlf_pkg::ACT_LOAD) begin
                sx[bt.idx] = bt.px;
                sy[bt.idx] = bt.py;
            end else begin
                run_trial(bt.sa, bt.sb);
                if (bt.last) begin
                    fits_due.push_back(best);
                    clear_best();
                end
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch in %s: got %h, expected %h", what, got, want);
            errors++;
        endtask

        task check_fit(logic [rlf_pkg::OUT_TDATA_W-1:0] data, logic user);
            t_fit w;
            if (fits_due.size() == 0) begin
                report("unexpected result beat", data[63:0], 64'd0);
                return;
            end
            w = fits_due.pop_front();
            if (data[31:0] !== w.slope) begin
                report("slope", 64'(data[31:0]), 64'(w.slope));
            end
            if (data[79:32] !== w.icpt) begin
                report("intercept", 64'(data[79:32]), 64'(w.icpt));
            end
            if (data[127:80] !== w.err) begin
                report("mean_error", 64'(data[127:80]), 64'(w.err));
            end
            if (user !== w.found) begin
                report("found", 64'(user), 64'(w.found));
            end
        endtask
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [rlf_pkg::IN_TDATA_W-1:0]      s_axis_tdata = '0;
    logic                                s_axis_tuser = 1'b0;
    logic                                s_axis_tlast = 1'b0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [rlf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;
    logic                                m_axis_tuser;
    logic                                i_cfg_we = 1'b0;
    logic                                i_cfg_index = 1'b0;
    logic [IXW-1:0]                      i_cfg_data = '0;

    line_fit_scoreboard sb = new();
    bit                 rx_hold_req = 1'b0;
    int                 lo_now = 0, hi_now = 359;

    ransac_line_fit_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                gap = 5000;
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            end
            repeat (gap) begin
                m_axis_tready <= 1'b0;
                @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_fit(m_axis_tdata, m_axis_tuser);
        end
    end

    task automatic send_beat(t_beat bt, bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= bt.act;
        s_axis_tlast  <= bt.last;
        s_axis_tdata  <= {5'd0, bt.sb, bt.sa, bt.py, bt.px, bt.idx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_beat(bt);
    endtask

    task automatic load_point(int idx, logic [15:0] x, logic [15:0] y);
        t_beat bt;
        bt = '0;
        bt.act = rlf_pkg::ACT_LOAD;
        bt.idx = IXW'(idx);
        bt.px = x;
        bt.py = y;
        bt.sa = IXW'($urandom);
        bt.sb = IXW'($urandom);
        bt.last = 1'($urandom);
        send_beat(bt);
    endtask

    task automatic trial(int a, int b, bit last, bit no_gap = 1'b0);
        t_beat bt;
        bt = '0;
        bt.act = rlf_pkg::ACT_TRIAL;
        bt.idx = IXW'($urandom);
        bt.px = 16'($urandom);
        bt.py = 16'($urandom);
        bt.sa = IXW'(a);
        bt.sb = IXW'(b);
        bt.last = last;
        send_beat(bt, no_gap);
    endtask

    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        while (sb.fits_due.size() != 0) @(posedge i_clk);
        repeat (800) @(posedge i_clk);
    endtask

    task automatic set_window(int lo, int hi);
        drain_and_settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= rlf_pkg::CFG_FIRST;
        i_cfg_data  <= IXW'(lo);
        @(posedge i_clk);
        sb.set_window(rlf_pkg::CFG_FIRST, IXW'(lo));
        i_cfg_index <= rlf_pkg::CFG_LAST;
        i_cfg_data  <= IXW'(hi);
        @(posedge i_clk);
        sb.set_window(rlf_pkg::CFG_LAST, IXW'(hi));
        i_cfg_we <= 1'b0;
        lo_now = lo;
        hi_now = hi;
    endtask

    function automatic logic [31:0] line_point();
        int x, y;
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1, 2: return $urandom;
            default: begin
                x = $urandom_range(0, 4000) - 2000;
                y = x / 2 + 300 + $urandom_range(0, 20) - 10;
                return {y[15:0], x[15:0]};
            end
        endcase
    endfunction

    function automatic int pick_sample();
        if (lo_now > hi_now || $urandom_range(0, 9) == 0) return $urandom_range(0, 511);
        return $urandom_range(lo_now, hi_now);
    endfunction

    task automatic random_items(int count);
        logic [31:0] p;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                p = line_point();
                load_point($urandom_range(0, 511), p[15:0], p[31:16]);
            end else begin
                trial(pick_sample(), pick_sample(), $urandom_range(0, 3) == 0);
            end
        end
        trial(pick_sample(), pick_sample(), 1'b1);
    endtask

    initial begin
        logic [31:0] p;
        int          wins [8][2];
        wins = '{'{0, 511}, '{0, 7}, '{100, 140}, '{511, 511},
                 '{300, 200}, '{0, 0}, '{10, 60}, '{0, 0}};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_point(0, 16'h8000, 16'h7FFF);
        load_point(1, 16'h7FFF, 16'h8000);
        load_point(2, 16'h0000, 16'h0000);
        load_point(3, 16'h0000, -16'sd30000);
        load_point(4, 16'h0001, 16'sd30000);
        load_point(5, 16'h0001, 16'sd100);
        for (int i = 6; i < NPTS; i++) begin
            p = line_point();
            load_point(i, p[15:0], p[31:16]);
        end

        trial(4, 5, 1'b1);
        trial(0, 1, 1'b1);
        trial(3, 4, 1'b1);
        trial(400, 5, 1'b1);
        trial(10, 20, 1'b0);
        trial(10, 20, 1'b0);
        trial(30, 40, 1'b1);
        trial(0, 1, 1'b0);
        trial(4, 5, 1'b1);
        load_point(6, 16'h7FFF, 16'h7FFF);
        trial(6, 0, 1'b1);
        trial(1, 3, 1'b0);
        trial(2, 2, 1'b1);

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) set_window($urandom_range(0, 511), $urandom_range(0, 511));
            else set_window(wins[ph][0], wins[ph][1]);
            if (ph == 1) begin
                rx_hold_req = 1'b1;
                for (int k = 0; k < 12; k++) trial(pick_sample(), pick_sample(), 1'b1, 1'b1);
            end
            random_items(60);
        end
        set_window(0, 359);
        random_items(40);

        drain_and_settle();
        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
